// ===== hw/rtl/pre_pkg.sv =====
`default_nettype none
package pre_pkg;

  localparam int PageW      = 8;
  localparam int MaxRes     = 64;
  localparam int OrderAw    = 6;
  localparam int CountW     = 7;
  localparam int SwapW      = 8;
  localparam int SeedW      = 16;
  localparam int OutW       = 64;

  localparam logic [1:0] ST_ABSENT   = 2'd0;
  localparam logic [1:0] ST_SWAPPED  = 2'd1;
  localparam logic [1:0] ST_RESIDENT = 2'd2;

  localparam logic [1:0] POL_FIFO   = 2'd0;
  localparam logic [1:0] POL_LRU    = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;
  localparam logic [1:0] REG_SWAP   = 2'd2;
  localparam logic [1:0] REG_SEED   = 2'd3;

  localparam logic [15:0] LFSR_MASK = 16'hB400;

  typedef struct packed {
    logic [1:0]        policy_mode;
    logic [CountW-1:0] memory_frames;
    logic [SwapW-1:0]  swap_slots;
    logic [SeedW-1:0]  random_seed;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [PageW-1:0] rd_addr;
    logic             wr_en;
    logic [PageW-1:0] wr_addr;
    logic [1:0]       wr_data;
    logic             clear;
  } stat_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/page_replacement_engine_unit.sv =====
`default_nettype none
// Page replacement engine: demand paging with FIFO, LRU or random victims.
// Input stream: s_tdata carries the referenced page, s_tuser a start-of-run
// flag that clears all tables and counters before that reference.
// Output stream: one result per reference, packed in m_tdata.
// Configuration: APB registers at 0x0 policy, 0x4 frames, 0x8 swap slots,
// 0xC random seed; write only while no reference is in flight.
// Steps: a hit or a free-frame fill passes the decide and finish states to
// the output register. An LRU hit scans the resident list (read then compare
// each entry) then closes the gap (read then write each entry); a replacement
// reads the victim and shifts the list likewise. Random choice adds a
// bit-serial remainder step. The walks over the resident list set the rate.
// One reference is processed at a time; the next is taken once the result
// is in the output register, even while that result waits for m_tready.
// Reset clears the status table at once through per-page valid bits.
module page_replacement_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] page_number
  input  wire logic        s_tuser,  // [0] start_run
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] page_fault, [1] evicted_valid, [9:2] evicted_page, [10] full_error,
  // [42:11] fault_total, [49:43] resident_total, [57:50] swap_total, zeros above
  output logic [63:0]      m_tdata
);

  pre_pkg::cfg_t cfg;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy_mode   <= pre_pkg::POL_FIFO;
      cfg.memory_frames <= 7'd64;
      cfg.swap_slots    <= '0;
      cfg.random_seed   <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        pre_pkg::REG_POLICY: cfg.policy_mode   <= pwdata[1:0];
        pre_pkg::REG_FRAMES: cfg.memory_frames <= pwdata[6:0];
        pre_pkg::REG_SWAP:   cfg.swap_slots    <= pwdata[7:0];
        pre_pkg::REG_SEED:   cfg.random_seed   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (reg_sel)
      pre_pkg::REG_POLICY: prdata = {30'd0, cfg.policy_mode};
      pre_pkg::REG_FRAMES: prdata = {25'd0, cfg.memory_frames};
      pre_pkg::REG_SWAP:   prdata = {24'd0, cfg.swap_slots};
      pre_pkg::REG_SEED:   prdata = {16'd0, cfg.random_seed};
      default:             prdata = '0;
    endcase
  end

  pre_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/pre_status_mem.sv =====
`default_nettype none
module pre_status_mem (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pre_pkg::stat_req_t req,
  output logic [1:0]             rd_data
);

  logic [1:0] mem [256];
  logic [255:0] valid;
  logic [1:0] rd_raw;
  logic       rd_valid;

  // status store, one row per page
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_addr];
    end
  end

  // valid bits: an unwritten page reads as absent
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid <= valid[req.rd_addr] && !req.clear;
    end
  end

  assign rd_data = rd_valid ? rd_raw : pre_pkg::ST_ABSENT;

endmodule
`default_nettype wire

// ===== hw/rtl/pre_order_mem.sv =====
`default_nettype none
module pre_order_mem (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [pre_pkg::OrderAw-1:0]   rd_addr,
  output logic [pre_pkg::PageW-1:0]          rd_data,
  input  wire logic                          wr_en,
  input  wire logic [pre_pkg::OrderAw-1:0]   wr_addr,
  input  wire logic [pre_pkg::PageW-1:0]     wr_data
);

  logic [pre_pkg::PageW-1:0] mem [pre_pkg::MaxRes];

  // resident list, oldest first
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pre_ctrl.sv =====
`default_nettype none
module pre_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pre_pkg::cfg_t              cfg,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,
  input  wire logic                       s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [pre_pkg::OutW-1:0]        m_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SRCH_RD, S_SRCH_CMP, S_MOD, S_VREAD, S_VCAP,
    S_SH_RD, S_SH_WR, S_FINISH
  } state_t;

  state_t     state;
  logic [7:0] page;
  logic [6:0] count;
  logic [7:0] swap_cnt;
  logic [31:0] faults;
  logic       halted;
  logic [15:0] lfsr;
  logic [15:0] dividend;
  logic [6:0] rem;
  logic [3:0] bit_cnt;
  logic [5:0] idx;
  logic       fault;
  logic       ev_valid;
  logic [7:0] ev_page;

  pre_pkg::stat_req_t sreq;
  logic [1:0] st;
  logic       o_rd_en, o_wr_en;
  logic [5:0] o_rd_addr, o_wr_addr;
  logic [7:0] o_wr_data, o_rd_data;

  logic [6:0] limit;
  logic       mem_full, swap_full;
  logic [6:0] idx_inc;
  logic [6:0] last_pos;
  logic [7:0] rem_sh;
  logic [15:0] lfsr_next;
  logic [15:0] seed_eff;
  logic       out_free;

  pre_status_mem u_stat (.clk(clk), .rst(rst), .req(sreq), .rd_data(st));

  pre_order_mem u_order (
    .clk(clk), .rd_en(o_rd_en), .rd_addr(o_rd_addr), .rd_data(o_rd_data),
    .wr_en(o_wr_en), .wr_addr(o_wr_addr), .wr_data(o_wr_data)
  );

  // derived limits and helpers
  always_comb begin
    if (cfg.memory_frames == 7'd0) begin
      limit = 7'd1;
    end else if (cfg.memory_frames > 7'(pre_pkg::MaxRes)) begin
      limit = 7'(pre_pkg::MaxRes);
    end else begin
      limit = cfg.memory_frames;
    end
    mem_full  = count >= limit;
    swap_full = swap_cnt >= cfg.swap_slots;
    idx_inc   = {1'b0, idx} + 7'd1;
    last_pos  = count - 7'd1;
    rem_sh    = {rem, dividend[15]};
    lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? pre_pkg::LFSR_MASK : 16'd0);
    seed_eff  = (cfg.random_seed == 16'd0) ? 16'd1 : cfg.random_seed;
    out_free  = !m_tvalid || m_tready;
  end

  assign s_tready = (state == S_IDLE);

  // memory requests
  always_comb begin
    sreq          = '0;
    sreq.rd_addr  = s_tdata;
    sreq.wr_addr  = page;
    sreq.wr_data  = pre_pkg::ST_RESIDENT;
    o_rd_en       = 1'b0;
    o_rd_addr     = idx;
    o_wr_en       = 1'b0;
    o_wr_addr     = idx;
    o_wr_data     = o_rd_data;
    case (state)
      S_IDLE: begin
        sreq.rd_en = s_tvalid;
        sreq.clear = s_tvalid && s_tuser;
      end
      S_DECIDE: begin
        if (!halted && page != 8'd0 && st != pre_pkg::ST_RESIDENT
            && !(st == pre_pkg::ST_ABSENT && mem_full && swap_full) && !mem_full) begin
          sreq.wr_en = 1'b1;
          o_wr_en    = 1'b1;
          o_wr_addr  = count[5:0];
          o_wr_data  = page;
        end
      end
      S_SRCH_RD: begin
        o_rd_en = 1'b1;
      end
      // victim slot: list head, or the remainder under random choice
      S_VREAD: begin
        o_rd_en = 1'b1;
        if (cfg.policy_mode == pre_pkg::POL_RANDOM) begin
          o_rd_addr = rem[5:0];
        end
      end
      S_VCAP: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = o_rd_data;
        sreq.wr_data = pre_pkg::ST_SWAPPED;
      end
      S_SH_RD: begin
        if (idx_inc < count) begin
          o_rd_en   = 1'b1;
          o_rd_addr = idx_inc[5:0];
        end else begin
          o_wr_en    = 1'b1;
          o_wr_addr  = last_pos[5:0];
          o_wr_data  = page;
          sreq.wr_en = 1'b1;
        end
      end
      S_SH_WR: begin
        o_wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer, run state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      swap_cnt <= '0;
      faults   <= '0;
      halted   <= 1'b0;
      lfsr     <= 16'd1;
      m_tvalid <= 1'b0;
    end else begin
      // the finish state loads the next result itself
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            page     <= s_tdata;
            fault    <= 1'b0;
            ev_valid <= 1'b0;
            ev_page  <= '0;
            if (s_tuser) begin
              count    <= '0;
              swap_cnt <= '0;
              faults   <= '0;
              halted   <= 1'b0;
              lfsr     <= seed_eff;
            end
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          idx <= '0;
          if (halted || page == 8'd0) begin
            state <= S_FINISH;
          end else if (st == pre_pkg::ST_RESIDENT) begin
            state <= (cfg.policy_mode == pre_pkg::POL_LRU) ? S_SRCH_RD : S_FINISH;
          end else if (st == pre_pkg::ST_ABSENT && mem_full && swap_full) begin
            halted <= 1'b1;
            state  <= S_FINISH;
          end else begin
            fault <= 1'b1;
            if (faults != 32'hFFFF_FFFF) begin
              faults <= faults + 32'd1;
            end
            if (mem_full) begin
              ev_valid <= 1'b1;
              if (st == pre_pkg::ST_ABSENT) begin
                swap_cnt <= swap_cnt + 8'd1;
              end
              if (cfg.policy_mode == pre_pkg::POL_RANDOM) begin
                lfsr     <= lfsr_next;
                dividend <= lfsr_next;
                rem      <= '0;
                bit_cnt  <= '0;
                state    <= S_MOD;
              end else begin
                state <= S_VREAD;
              end
            end else begin
              count <= count + 7'd1;
              state <= S_FINISH;
            end
          end
        end
        S_SRCH_RD: state <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if (o_rd_data == page) begin
            state <= S_SH_RD;
          end else if (idx_inc >= count) begin
            state <= S_FINISH;
          end else begin
            idx   <= idx_inc[5:0];
            state <= S_SRCH_RD;
          end
        end
        // restoring remainder, one bit a cycle
        S_MOD: begin
          if (rem_sh >= {1'b0, count}) begin
            rem <= 7'(rem_sh - {1'b0, count});
          end else begin
            rem <= rem_sh[6:0];
          end
          dividend <= {dividend[14:0], 1'b0};
          bit_cnt  <= bit_cnt + 4'd1;
          if (bit_cnt == 4'd15) begin
            state <= S_VREAD;
          end
        end
        S_VREAD: begin
          if (cfg.policy_mode == pre_pkg::POL_RANDOM) begin
            idx <= rem[5:0];
          end
          state <= S_VCAP;
        end
        S_VCAP: begin
          ev_page <= o_rd_data;
          state   <= S_SH_RD;
        end
        S_SH_RD: begin
          state <= (idx_inc < count) ? S_SH_WR : S_FINISH;
        end
        S_SH_WR: begin
          idx   <= idx_inc[5:0];
          state <= S_SH_RD;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, swap_cnt, count, faults, halted, ev_page, ev_valid, fault};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [7:0] page;
    logic       restart;
  } page_ref_t;

  // lowest field last, matching the m_tdata packing
  typedef struct packed {
    logic [7:0]  swap_cnt;
    logic [6:0]  res_cnt;
    logic [31:0] fault_cnt;
    logic        full_err;
    logic [7:0]  ev_page;
    logic        ev_valid;
    logic        fault;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  page_replacement_engine_unit uut (.*);

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [1:0]  pol;
  logic [6:0]  frames;
  logic [7:0]  swap_lim;
  logic [15:0] seed;
  logic [1:0]  status [0:255];
  logic [7:0]  order [0:63];
  int unsigned n_res, n_swap;
  logic [31:0] n_fault;
  logic        halted;
  logic [15:0] lfsr;

  page_ref_t    pending_refs[$];
  page_result_t expected_results[$];
  int           errors = 0;
  int           send_idle = 0, recv_idle = 0;
  int           hold_cycles = 0;
  longint       cycle_cnt = 0;

  function automatic void clear_tables();
    for (int i = 0; i < 256; i++) status[i] = pre_pkg::ST_ABSENT;
    n_res = 0; n_swap = 0; n_fault = '0; halted = 1'b0;
    lfsr = (seed == 16'd0) ? 16'd1 : seed;
  endfunction

  // remove list entry and close the gap
  function automatic logic [7:0] pull_entry(int unsigned idx);
    logic [7:0] p;
    p = order[idx];
    for (int unsigned i = idx; i + 1 < n_res; i++) order[i] = order[i+1];
    n_res--;
    return p;
  endfunction

  function automatic void push_page(logic [7:0] p);
    order[n_res] = p;
    n_res++;
    status[p] = pre_pkg::ST_RESIDENT;
  endfunction

  function automatic page_result_t predict_paging(page_ref_t r);
    page_result_t res;
    int unsigned lim, idx;
    logic [1:0] st;
    logic full;
    logic [7:0] victim;
    logic lsb;
    res = '0;
    if (r.restart) clear_tables();
    if (!halted && r.page != 8'd0) begin
      st = status[r.page];
      lim = (frames == 0) ? 1 : (frames > 64 ? 64 : frames);
      full = n_res >= lim;
      if (st == pre_pkg::ST_RESIDENT) begin
        if (pol == pre_pkg::POL_LRU) begin
          for (int unsigned i = 0; i < n_res; i++) begin
            if (order[i] == r.page) begin
              void'(pull_entry(i));
              push_page(r.page);
              break;
            end
          end
        end
      end else if (st == pre_pkg::ST_ABSENT && full && n_swap >= swap_lim) begin
        halted = 1'b1;
      end else begin
        if (full) begin
          idx = 0;
          if (pol == pre_pkg::POL_RANDOM) begin
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb) lfsr = lfsr ^ pre_pkg::LFSR_MASK;
            idx = lfsr % n_res;
          end
          victim = pull_entry(idx);
          push_page(r.page);
          status[victim] = pre_pkg::ST_SWAPPED;
          res.ev_valid = 1'b1;
          res.ev_page = victim;
          if (st == pre_pkg::ST_ABSENT) n_swap++;
        end else begin
          push_page(r.page);
        end
        res.fault = 1'b1;
        if (n_fault != 32'hFFFF_FFFF) n_fault++;
      end
    end
    res.full_err = halted;
    res.fault_cnt = n_fault;
    res.res_cnt = n_res[6:0];
    res.swap_cnt = n_swap[7:0];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_refs.size() > 0 && ($urandom_range(99) >= send_idle)) begin
        s_tdata  <= pending_refs[0].page;
        s_tuser  <= pending_refs[0].restart;
        s_tvalid <= 1'b1;
        expected_results.insert(expected_results.size(),
                                predict_paging(pending_refs.pop_front()));
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    page_result_t got, exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[57:0];
      if (expected_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected transfer: %h", m_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r || m_tdata[63:58] !== 6'd0) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: expected %h actual %h", exp_r, m_tdata);
        end
      end
    end
    if (cycle_cnt > 3_000_000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pre_pkg::REG_POLICY: pol = val[1:0];
      pre_pkg::REG_FRAMES: frames = val[6:0];
      pre_pkg::REG_SWAP:   swap_lim = val[7:0];
      default:             seed = val[15:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_refs.size() == 0 && expected_results.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic add_ref(int pg, bit rs);
    page_ref_t r;
    r.page = pg[7:0];
    r.restart = rs;
    pending_refs.insert(pending_refs.size(), r);
  endtask

  // a well-formed run: restart then references mostly over a working set of 4 to 255 pages
  task automatic add_run(int len);
    int span;
    span = $urandom_range(4, 255);
    add_ref($urandom_range(1, span), 1'b1);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(19) == 0) add_ref($urandom_range(0, 255), 1'b0);
      else add_ref($urandom_range(1, span), 1'b0);
    end
  endtask

  task automatic random_cfg();
    write_reg(pre_pkg::REG_POLICY, $urandom_range(0, 3));
    write_reg(pre_pkg::REG_FRAMES, ($urandom_range(9) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 12));
    write_reg(pre_pkg::REG_SWAP, ($urandom_range(4) == 0) ? 255 : $urandom_range(0, 40));
    write_reg(pre_pkg::REG_SEED, $urandom_range(0, 65535));
  endtask

  initial begin
    pol = pre_pkg::POL_FIFO; frames = 7'd64; swap_lim = 8'd0; seed = 16'd1;
    clear_tables();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: fill, hit, evict, page extremes, halt and restart
    write_reg(pre_pkg::REG_FRAMES, 2);
    write_reg(pre_pkg::REG_SWAP, 2);
    add_ref(1, 1'b1); add_ref(255, 1'b0); add_ref(1, 1'b0);
    add_ref(0, 1'b0); add_ref(3, 1'b0); add_ref(1, 1'b0);
    add_ref(4, 1'b0); add_ref(5, 1'b0); add_ref(6, 1'b0);
    add_ref(7, 1'b1);
    drain();
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_LRU);
    add_ref(1, 1'b1); add_ref(2, 1'b0); add_ref(1, 1'b0);
    add_ref(3, 1'b0); add_ref(2, 1'b0); add_ref(170, 1'b0);
    drain();
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_RANDOM);
    write_reg(pre_pkg::REG_FRAMES, 64);
    write_reg(pre_pkg::REG_SWAP, 255);
    write_reg(pre_pkg::REG_SEED, 0);
    for (int i = 0; i < 66; i++) add_ref(i + 1, i == 0);
    add_ref(2, 1'b0);
    drain();
    write_reg(pre_pkg::REG_SEED, 16'hFFFF);
    write_reg(pre_pkg::REG_POLICY, 3);
    write_reg(pre_pkg::REG_FRAMES, 0);
    add_ref(85, 1'b1); add_ref(9, 1'b0); add_ref(85, 1'b0);
    drain();

    // random phases with varying idle rates
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 34) : 0;
      recv_idle = (ph == 2) ? 67 : (ph == 3 ? 34 : 0);
      random_cfg();
      for (int k = 0; k < 4; k++) add_run($urandom_range(15, 45));
      if (ph == 0) hold_cycles = 3000;
      drain();
    end
    send_idle = 0; recv_idle = 0;
    write_reg(pre_pkg::REG_FRAMES, 127);
    add_run(40);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== page_replacement_engine_unit.f =====
hw/rtl/pre_pkg.sv
hw/rtl/pre_status_mem.sv
hw/rtl/pre_order_mem.sv
hw/rtl/pre_ctrl.sv
hw/rtl/page_replacement_engine_unit.sv
dv/tb_top.sv
